// ===== rtl/cdpm_pkg.sv =====
package cdpm_pkg;

    // Item opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT_EARLY = 2'd0,
        CFG_TIMEOUT_LAST  = 2'd1,
        CFG_TIMEOUT_RUN   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    localparam int CFG_W = 13;

    localparam logic [CFG_W-1:0] TIMEOUT_EARLY_RST = 13'd1100;
    localparam logic [CFG_W-1:0] TIMEOUT_LAST_RST  = 13'd4100;
    localparam logic [CFG_W-1:0] TIMEOUT_RUN_RST   = 13'd300;
    localparam logic [CFG_W-1:0] IDLE_MAX          = 13'd8191;

    // ASCII codes
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_1    = 8'h31;
    localparam logic [7:0] CHAR_2    = 8'h32;
    localparam logic [7:0] CHAR_3    = 8'h33;
    localparam logic [7:0] CHAR_4    = 8'h34;
    localparam logic [7:0] CHAR_5    = 8'h35;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5A;

    // Receiver mode, one-hot
    typedef enum logic [7:0] {
        MODE_INACTIVE = 8'b0000_0001,
        MODE_CD_FIVE  = 8'b0000_0010,
        MODE_CD_FOUR  = 8'b0000_0100,
        MODE_CD_THREE = 8'b0000_1000,
        MODE_CD_TWO   = 8'b0001_0000,
        MODE_CD_ONE   = 8'b0010_0000,
        MODE_CD_ZERO  = 8'b0100_0000,
        MODE_POSITION = 8'b1000_0000
    } t_mode;

    // Mode codes as shown on the result channel
    localparam logic [2:0] CODE_INACTIVE = 3'd0;
    localparam logic [2:0] CODE_CD_FIVE  = 3'd1;
    localparam logic [2:0] CODE_CD_FOUR  = 3'd2;
    localparam logic [2:0] CODE_CD_THREE = 3'd3;
    localparam logic [2:0] CODE_CD_TWO   = 3'd4;
    localparam logic [2:0] CODE_CD_ONE   = 3'd5;
    localparam logic [2:0] CODE_CD_ZERO  = 3'd6;
    localparam logic [2:0] CODE_POSITION = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] timeout_early;
        logic [CFG_W-1:0] timeout_last;
        logic [CFG_W-1:0] timeout_run;
    } t_cfg;

    typedef struct packed {
        logic       new_position;
        logic [7:0] from_node;
        logic [7:0] to_node;
        logic [7:0] next_node;
        logic [9:0] percent;
        logic [2:0] rx_mode;
    } t_result;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_INACTIVE: c = CODE_INACTIVE;
            MODE_CD_FIVE:  c = CODE_CD_FIVE;
            MODE_CD_FOUR:  c = CODE_CD_FOUR;
            MODE_CD_THREE: c = CODE_CD_THREE;
            MODE_CD_TWO:   c = CODE_CD_TWO;
            MODE_CD_ONE:   c = CODE_CD_ONE;
            MODE_CD_ZERO:  c = CODE_CD_ZERO;
            MODE_POSITION: c = CODE_POSITION;
            default:       c = CODE_INACTIVE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cdpm_in_if.sv =====
interface cdpm_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// ===== rtl/cdpm_out_if.sv =====
interface cdpm_out_if;
    logic       valid;
    logic       ready;
    logic       new_position;
    logic [7:0] from_node;
    logic [7:0] to_node;
    logic [7:0] next_node;
    logic [9:0] percent;
    logic [2:0] rx_mode;

    modport source (output valid, output new_position, output from_node, output to_node,
                    output next_node, output percent, output rx_mode, input ready);
    modport sink   (input valid, input new_position, input from_node, input to_node,
                    input next_node, input percent, input rx_mode, output ready);
endinterface

// ===== rtl/cdpm_parse.sv =====
module cdpm_parse #(
    parameter int MSG_LEN = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    input  cdpm_pkg::t_cfg    i_cfg,
    output cdpm_pkg::t_result o_result
);
    import cdpm_pkg::*;

    localparam int CNT_W = $clog2(MSG_LEN + 1);
    localparam int IDX_W = $clog2(MSG_LEN);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MSG_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MSG_LEN - 1);

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_store [MSG_LEN];
    logic [CFG_W-1:0] r_idle, n_idle;
    logic [7:0]       r_from, n_from;
    logic [7:0]       r_to, n_to;
    logic [7:0]       r_next, n_next;
    logic [9:0]       r_percent, n_percent;

    logic             store_we;
    logic             pulse;
    logic             msg_ok;
    logic [CFG_W-1:0] limit;
    logic [9:0]       pct_calc;
    logic [2:0]       cur_code;

    // Check the collected message: three capitals then three digits
    always_comb begin
        msg_ok = (r_store[0] >= CHAR_A) && (r_store[0] <= CHAR_Z)
              && (r_store[1] >= CHAR_A) && (r_store[1] <= CHAR_Z)
              && (r_store[2] >= CHAR_A) && (r_store[2] <= CHAR_Z)
              && (r_store[3] >= CHAR_0) && (r_store[3] <= CHAR_9)
              && (r_store[4] >= CHAR_0) && (r_store[4] <= CHAR_9)
              && (r_store[5] >= CHAR_0) && (r_store[5] <= CHAR_9);
        pct_calc = 10'(r_store[3][3:0]) * 10'd100
                 + 10'(r_store[4][3:0]) * 10'd10
                 + 10'(r_store[5][3:0]);
    end

    // Pick the idle limit of the current mode
    always_comb begin
        cur_code = mode_code(r_mode);
        if (cur_code < CODE_CD_ONE) begin
            limit = i_cfg.timeout_early;
        end else if (cur_code == CODE_CD_ONE) begin
            limit = i_cfg.timeout_last;
        end else begin
            limit = i_cfg.timeout_run;
        end
    end

    // Next state for one word
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_idle    = r_idle;
        n_from    = r_from;
        n_to      = r_to;
        n_next    = r_next;
        n_percent = r_percent;
        store_we  = 1'b0;
        pulse     = 1'b0;
        if (i_op == OP_TICK) begin
            n_idle = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;
            if (r_mode != MODE_INACTIVE && n_idle > limit) begin
                n_mode = MODE_INACTIVE;
            end
        end else begin
            n_idle = '0;
            if (cur_code <= CODE_CD_ONE) begin
                // Countdown digits select the countdown state, others are ignored
                unique case (i_rx_byte)
                    CHAR_5:  n_mode = MODE_CD_FIVE;
                    CHAR_4:  n_mode = MODE_CD_FOUR;
                    CHAR_3:  n_mode = MODE_CD_THREE;
                    CHAR_2:  n_mode = MODE_CD_TWO;
                    CHAR_1:  n_mode = MODE_CD_ONE;
                    CHAR_0:  n_mode = MODE_CD_ZERO;
                    default: n_mode = r_mode;
                endcase
            end else if (r_count < CNT_FULL) begin
                store_we = 1'b1;
                n_count  = r_count + 1'b1;
                if (i_rx_byte == CHAR_CR) begin
                    n_count = '0;
                    if (r_count == CNT_LAST) begin
                        n_mode = MODE_POSITION;
                        if (msg_ok) begin
                            pulse     = 1'b1;
                            n_from    = r_store[0];
                            n_to      = r_store[1];
                            n_next    = r_store[2];
                            n_percent = pct_calc;
                        end
                    end
                end
            end else begin
                // Overlong message: drop the byte and restart
                n_count = '0;
                n_mode  = MODE_POSITION;
            end
        end
    end

    // Advance state on each word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INACTIVE;
            r_count   <= '0;
            r_idle    <= '0;
            r_from    <= '0;
            r_to      <= '0;
            r_next    <= '0;
            r_percent <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_from    <= n_from;
            r_to      <= n_to;
            r_next    <= n_next;
            r_percent <= n_percent;
        end
    end

    // Message store, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    assign o_result.new_position = pulse;
    assign o_result.from_node    = n_from;
    assign o_result.to_node      = n_to;
    assign o_result.next_node    = n_next;
    assign o_result.percent      = n_percent;
    assign o_result.rx_mode      = mode_code(n_mode);

endmodule

// ===== rtl/countdown_position_msg_parser_core.sv =====
// Countdown and position message parser.
// Input channel i_rx carries one word per item: op 0 is a received UART byte
// in rx_byte, op 1 is a one millisecond tick. Output channel o_res returns one
// result word per input word: the new_position pulse, the latest node letters
// and percent, and the current receive mode (0 inactive, 1..6 countdown five
// to zero, 7 position).
// Timeouts are written through i_cfg_we / i_cfg_index / i_cfg_data while idle;
// index 0 early countdown, 1 last countdown, 2 run; index 3 is ignored.
// An accepted word sits in the input register; once the result register is free
// or read, the state steps and its result loads the result register with valid.
// Throughput is one word per cycle unless the receiver stalls.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; after that i_rx.ready drops until o_res.ready.
// Synchronous reset clears the valid flags of both registers, the mode, byte count,
// idle count, latched node letters and percent, and loads the default timeouts.
module countdown_position_msg_parser_core #(
    parameter int MSG_LEN = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cdpm_in_if.sink                       i_rx,
    cdpm_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cdpm_pkg::CFG_W-1:0]    i_cfg_data
);
    import cdpm_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_rx_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_result    core_res;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_early <= TIMEOUT_EARLY_RST;
            r_cfg.timeout_last  <= TIMEOUT_LAST_RST;
            r_cfg.timeout_run   <= TIMEOUT_RUN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT_EARLY: r_cfg.timeout_early <= i_cfg_data;
                CFG_TIMEOUT_LAST:  r_cfg.timeout_last  <= i_cfg_data;
                CFG_TIMEOUT_RUN:   r_cfg.timeout_run   <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_op      <= i_rx.op;
            r_rx_byte <= i_rx.rx_byte;
        end
    end

    cdpm_parse #(
        .MSG_LEN (MSG_LEN)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_op      (r_op),
        .i_rx_byte (r_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.new_position = r_res.new_position;
    assign o_res.from_node    = r_res.from_node;
    assign o_res.to_node      = r_res.to_node;
    assign o_res.next_node    = r_res.next_node;
    assign o_res.percent      = r_res.percent;
    assign o_res.rx_mode      = r_res.rx_mode;

endmodule

// ===== rtl/cdpm_check.sv =====
module cdpm_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_new_position,
    input logic [7:0] i_from_node,
    input logic [9:0] i_percent,
    input logic [2:0] i_rx_mode
);
    import cdpm_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its pulse
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_new_position))
        else $error("stalled result changed");

    // A new position is only reported in the position mode
    a_pulse_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_new_position |-> i_rx_mode == CODE_POSITION)
        else $error("new position outside position mode");

    // A new position carries a capital letter
    a_pulse_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_new_position |-> i_from_node >= CHAR_A && i_from_node <= CHAR_Z)
        else $error("new position with a bad node letter");

    // Percent stays in range
    a_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_percent <= 10'd999)
        else $error("percent out of range");

endmodule

bind countdown_position_msg_parser_core cdpm_check u_cdpm_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_new_position (o_res.new_position),
    .i_from_node    (o_res.from_node),
    .i_percent      (o_res.percent),
    .i_rx_mode      (o_res.rx_mode)
);
